// ===== src/tbsm_pkg.sv =====
// shared types and constants of the three-button set-up menu
package tbsm_pkg;

   localparam int DIGIT_WIDTH = 4;

   localparam logic [2:0] LED_G   = 3'b001;
   localparam logic [2:0] LED_Y   = 3'b010;
   localparam logic [2:0] LED_R   = 3'b100;
   localparam logic [2:0] LED_ALL = 3'b111;

   localparam logic [3:0] MODE_NONE = 4'd15;
   localparam logic [3:0] MODE_EU   = 4'd0;
   localparam logic [3:0] MODE_US   = 4'd1;
   localparam logic [3:0] MODE_ASIA = 4'd2;
   localparam logic [3:0] MODE_MIN  = 4'd3;
   localparam logic [3:0] MODE_MID  = 4'd4;
   localparam logic [3:0] MODE_MAX  = 4'd5;

   localparam logic [15:0] SECONDS_PER_MINUTE = 16'd60;
   localparam logic [15:0] SECONDS_PER_TEN    = 16'd10;
   localparam logic [7:0]  HOLD_LED_TICKS     = 8'd2;
   localparam logic [7:0]  STEP_MAX           = 8'd255;

   // register indexes
   localparam logic [2:0] REG_ENTER_LOW    = 3'd0;
   localparam logic [2:0] REG_ENTER_HIGH   = 3'd1;
   localparam logic [2:0] REG_MAX_DELAY    = 3'd2;
   localparam logic [2:0] REG_MIN_LOCK     = 3'd3;
   localparam logic [2:0] REG_MAX_LOCK     = 3'd4;
   localparam logic [2:0] REG_INIT_LOCK    = 3'd5;
   localparam logic [2:0] REG_INIT_RF_MODE = 3'd6;

   // register reset values
   localparam logic [7:0]  ENTER_LOW_RESET    = 8'd4;
   localparam logic [7:0]  ENTER_HIGH_RESET   = 8'd12;
   localparam logic [7:0]  MAX_DELAY_RESET    = 8'd6;
   localparam logic [15:0] MIN_LOCK_RESET     = 16'd2;
   localparam logic [15:0] MAX_LOCK_RESET     = 16'd1340;
   localparam logic [15:0] INIT_LOCK_RESET    = 16'd20;
   localparam logic [2:0]  INIT_RF_MODE_RESET = 3'd0;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SHOW_CUR_TIME,
      S_WAIT_SETUP,
      S_WAIT_SET_TIME,
      S_SET_TIME,
      S_SHOW_TIME,
      S_WAIT_SHOW_FREQ,
      S_SHOW_CUR_FREQ,
      S_SET_FREQ,
      S_SHOW_FREQ,
      S_CHECK_STOP
   } menu_state_type;

   typedef struct packed {
      logic [7:0]  enter_low;
      logic [7:0]  enter_high;
      logic [7:0]  max_delay;
      logic [15:0] min_lock_ticks;
      logic [15:0] max_lock_ticks;
   } cfg_type;

   typedef struct packed {
      logic        lock_load;
      logic [15:0] lock_value;
      logic        rf_load;
      logic [2:0]  rf_value;
   } load_type;

   typedef struct packed {
      logic [2:0]  led_levels;
      logic        menu_active;
      logic        save_request;
      logic        stop_request;
      logic        blink_request;
      logic [15:0] lock_ticks_now;
      logic [2:0]  rf_mode_now;
   } result_type;

endpackage

// ===== src/tbsm_core.sv =====
// menu state registers and the one-tick next-state logic
module tbsm_core #(
   parameter int TICKS_PER_SECOND = 2,
   parameter int DIGIT_LIMIT      = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                btn_green,
   input  logic                btn_yellow,
   input  logic                btn_red,
   input  tbsm_pkg::cfg_type   cfg,
   input  tbsm_pkg::load_type  load,
   output tbsm_pkg::result_type result
);
   import tbsm_pkg::*;

   localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX = DIGIT_WIDTH'(DIGIT_LIMIT);
   localparam logic [15:0] TPS = 16'(TICKS_PER_SECOND);
   // exact reciprocal for 16-bit dividends
   localparam int  DIV_SHIFT = 16 + $clog2(TICKS_PER_SECOND);
   localparam longint DIV_MULT_L =
      ((64'd1 << DIV_SHIFT) + longint'(TICKS_PER_SECOND) - 1) / TICKS_PER_SECOND;
   localparam logic [16:0] DIV_MULT = 17'(DIV_MULT_L);

   typedef struct packed {
      logic [2:0]  led;
      logic [7:0]  sc;
      logic [15:0] sl;
      logic        done;
   } time_pulse_type;

   typedef struct packed {
      logic [2:0] led;
      logic [7:0] sc;
      logic       done;
   } freq_pulse_type;

   menu_state_type         state_ff, state_in;
   logic [7:0]             step_count_ff, step_count_in;
   logic [15:0]            seconds_left_ff, seconds_left_in;
   logic [DIGIT_WIDTH-1:0] unit_ff, unit_in, tens_ff, tens_in, minute_ff, minute_in;
   logic                   await_ff, await_in;
   logic [3:0]             pending_mode_ff, pending_mode_in;
   logic [15:0]            lock_ff, lock_in;
   logic [2:0]             rf_ff, rf_in;
   logic [2:0]             led_ff, led_in;
   // seconds_left still to be derived from the registered lock time
   logic                   sec_load_ff, sec_load_in;

   logic [32:0] div_prod;
   logic [15:0] div_secs;

   assign div_prod = 33'(lock_ff) * 33'(DIV_MULT);
   assign div_secs = 16'(div_prod >> DIV_SHIFT);

   function automatic time_pulse_type time_pulse(input logic [2:0] led,
                                                 input logic [7:0] sc,
                                                 input logic [15:0] sl);
      time_pulse_type p;
      p.led = led;
      p.sl  = sl;
      if (sc == 8'd0) begin
         if (sl >= SECONDS_PER_MINUTE) begin
            p.led = led | LED_R;
            p.sl  = sl - SECONDS_PER_MINUTE;
         end else if (sl >= SECONDS_PER_TEN) begin
            p.led = led | LED_Y;
            p.sl  = sl - SECONDS_PER_TEN;
         end else if (sl >= 16'd1) begin
            p.led = led | LED_G;
            p.sl  = sl - 16'd1;
         end
         p.sc = 8'd1;
      end else begin
         p.led = 3'b000;
         p.sc  = 8'd0;
      end
      p.done = (p.sl == 16'd0) && (p.sc == 8'd0);
      return p;
   endfunction

   function automatic freq_pulse_type freq_pulse(input logic [2:0] led,
                                                 input logic [7:0] sc,
                                                 input logic [2:0] rf);
      freq_pulse_type p;
      p.led  = led;
      p.sc   = sc;
      p.done = 1'b0;
      case (sc)
         8'd0: begin
            if (rf == MODE_EU[2:0] || rf == MODE_MIN[2:0]) p.led = led | LED_G;
            else if (rf == MODE_US[2:0] || rf == MODE_MID[2:0]) p.led = led | LED_Y;
            else if (rf == MODE_ASIA[2:0] || rf == MODE_MAX[2:0]) p.led = led | LED_R;
            p.sc = 8'd1;
         end
         8'd1: begin
            p.led = 3'b000;
            p.sc  = 8'd2;
         end
         8'd2: begin
            if (rf == MODE_MIN[2:0]) p.led = led | LED_G;
            else if (rf == MODE_MID[2:0]) p.led = led | LED_Y;
            else if (rf == MODE_MAX[2:0]) p.led = led | LED_R;
            p.sc = 8'd3;
         end
         default: begin
            p.led  = 3'b000;
            p.done = 1'b1;
         end
      endcase
      return p;
   endfunction

   always_comb begin
      logic           any;
      logic           active, save, stop, blink;
      logic [15:0]    t;
      time_pulse_type tp;
      freq_pulse_type fp;

      any    = btn_green || btn_yellow || btn_red;
      active = (state_ff != S_IDLE);
      save   = 1'b0;
      stop   = 1'b0;
      blink  = 1'b0;
      t      = 16'(minute_ff) * SECONDS_PER_MINUTE + 16'(tens_ff) * SECONDS_PER_TEN
               + 16'(unit_ff);
      t      = t * TPS;
      tp     = '0;
      fp     = '0;

      state_in        = state_ff;
      step_count_in   = step_count_ff;
      seconds_left_in = sec_load_ff ? div_secs : seconds_left_ff;
      unit_in         = unit_ff;
      tens_in         = tens_ff;
      minute_in       = minute_ff;
      await_in        = await_ff;
      pending_mode_in = pending_mode_ff;
      lock_in         = lock_ff;
      rf_in           = rf_ff;
      led_in          = led_ff;
      sec_load_in     = 1'b0;

      case (state_ff)
         S_SHOW_CUR_TIME: begin
            tp = time_pulse(led_in, step_count_in, seconds_left_in);
            led_in          = tp.led;
            step_count_in   = tp.sc;
            seconds_left_in = tp.sl;
            if (tp.done) begin
               state_in      = S_WAIT_SETUP;
               step_count_in = 8'd0;
            end else if (any) begin
               state_in = S_IDLE;
            end
         end
         S_WAIT_SETUP: begin
            if (btn_yellow) begin
               state_in      = S_WAIT_SET_TIME;
               unit_in       = '0;
               tens_in       = '0;
               minute_in     = '0;
               step_count_in = 8'd0;
               await_in      = 1'b0;
               blink         = 1'b1;
            end else if (btn_green) begin
               state_in      = S_WAIT_SHOW_FREQ;
               led_in        = led_in | LED_G;
               step_count_in = 8'd0;
            end else if (btn_red) begin
               state_in      = S_CHECK_STOP;
               led_in        = led_in | LED_R;
               step_count_in = 8'd0;
            end else begin
               if (step_count_in != STEP_MAX) step_count_in = step_count_in + 8'd1;
               if (step_count_in >= cfg.max_delay) state_in = S_IDLE;
            end
         end
         S_CHECK_STOP: begin
            if (btn_red) begin
               if (step_count_in != STEP_MAX) step_count_in = step_count_in + 8'd1;
            end else begin
               state_in = S_IDLE;
               if (step_count_in > cfg.enter_low && step_count_in < cfg.enter_high) begin
                  stop          = 1'b1;
                  step_count_in = 8'd0;
                  led_in        = led_in & ~LED_R;
               end else begin
                  blink = 1'b1;
               end
            end
         end
         S_WAIT_SET_TIME: begin
            if (!any) state_in = S_SET_TIME;
         end
         S_SET_TIME: begin
            if (!(await_ff && any)) begin
               await_in = 1'b0;
               if (btn_green) begin
                  if (unit_ff < DIGIT_MAX) begin
                     led_in        = led_in | LED_G;
                     unit_in       = unit_ff + 1'b1;
                     await_in      = 1'b1;
                     step_count_in = 8'd0;
                  end
               end else if (btn_yellow) begin
                  if (tens_ff < DIGIT_MAX) begin
                     led_in        = led_in | LED_Y;
                     tens_in       = tens_ff + 1'b1;
                     await_in      = 1'b1;
                     step_count_in = 8'd0;
                  end
               end else if (btn_red) begin
                  if (minute_ff < DIGIT_MAX) begin
                     led_in        = led_in | LED_R;
                     minute_in     = minute_ff + 1'b1;
                     await_in      = 1'b1;
                     step_count_in = 8'd0;
                  end
               end else if (step_count_in >= cfg.max_delay) begin
                  led_in = 3'b000;
                  if (t != 16'd0) begin
                     // minimum first, so the maximum wins when the limits cross
                     if (t < cfg.min_lock_ticks) t = cfg.min_lock_ticks;
                     if (t > cfg.max_lock_ticks) t = cfg.max_lock_ticks;
                     lock_in       = t;
                     state_in      = S_SHOW_TIME;
                     step_count_in = 8'd1;
                     led_in        = LED_ALL;
                     sec_load_in   = 1'b1;
                     save          = 1'b1;
                  end else begin
                     // empty time entry: keep the stored lock time
                     state_in      = S_IDLE;
                     step_count_in = 8'd0;
                  end
               end else begin
                  if (step_count_in != STEP_MAX) step_count_in = step_count_in + 8'd1;
                  led_in = 3'b000;
               end
            end
         end
         S_SHOW_TIME: begin
            tp = time_pulse(led_in, step_count_in, seconds_left_in);
            led_in          = tp.led;
            step_count_in   = tp.sc;
            seconds_left_in = tp.sl;
            if (tp.done) state_in = S_IDLE;
         end
         S_WAIT_SHOW_FREQ: begin
            if (btn_green) begin
               if (step_count_in != STEP_MAX) step_count_in = step_count_in + 8'd1;
            end else begin
               led_in = led_in & ~LED_G;
               if (step_count_in >= cfg.enter_low && step_count_in < cfg.enter_high) begin
                  led_in        = 3'b000;
                  step_count_in = 8'd0;
                  state_in      = S_SHOW_CUR_FREQ;
               end else begin
                  state_in      = S_IDLE;
                  step_count_in = 8'd0;
               end
            end
         end
         S_SHOW_CUR_FREQ: begin
            fp = freq_pulse(led_in, step_count_in, rf_ff);
            led_in        = fp.led;
            step_count_in = fp.sc;
            if (fp.done) begin
               pending_mode_in = MODE_NONE;
               step_count_in   = 8'd0;
               state_in        = S_SET_FREQ;
            end
         end
         S_SET_FREQ: begin
            if (step_count_in != STEP_MAX) step_count_in = step_count_in + 8'd1;
            if (btn_green) begin
               led_in          = led_in | LED_G;
               pending_mode_in = MODE_EU;
            end
            if (btn_yellow) begin
               led_in          = led_in | LED_Y;
               pending_mode_in = MODE_US;
            end
            if (btn_red) begin
               led_in          = led_in | LED_R;
               pending_mode_in = MODE_ASIA;
            end
            if (step_count_in >= cfg.max_delay) begin
               // long press picks the power modes
               led_in = 3'b000;
               if (btn_green) pending_mode_in = MODE_MIN;
               if (btn_yellow) pending_mode_in = MODE_MID;
               if (btn_red) pending_mode_in = MODE_MAX;
               if (pending_mode_in != MODE_NONE) rf_in = pending_mode_in[2:0];
               step_count_in = 8'd0;
               save          = 1'b1;
               state_in      = S_SHOW_FREQ;
            end
         end
         S_SHOW_FREQ: begin
            fp = freq_pulse(led_in, step_count_in, rf_ff);
            led_in        = fp.led;
            step_count_in = fp.sc;
            if (fp.done) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
            if (btn_green && !btn_yellow && btn_red) begin
               active = 1'b1;
               if (step_count_in != STEP_MAX) step_count_in = step_count_in + 8'd1;
               if (step_count_in > HOLD_LED_TICKS) led_in = led_in | LED_G | LED_R;
            end else if (step_count_in > cfg.enter_low && step_count_in < cfg.enter_high) begin
               active        = 1'b1;
               state_in      = S_SHOW_CUR_TIME;
               step_count_in = 8'd1;
               led_in        = led_in | LED_ALL;
               sec_load_in   = 1'b1;
            end else begin
               step_count_in = 8'd0;
            end
         end
      endcase

      result.led_levels     = led_in;
      result.menu_active    = active;
      result.save_request   = save;
      result.stop_request   = stop;
      result.blink_request  = blink;
      result.lock_ticks_now = lock_in;
      result.rf_mode_now    = rf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         step_count_ff   <= 8'd0;
         seconds_left_ff <= 16'd0;
         unit_ff         <= '0;
         tens_ff         <= '0;
         minute_ff       <= '0;
         await_ff        <= 1'b0;
         pending_mode_ff <= MODE_NONE;
         lock_ff         <= INIT_LOCK_RESET;
         rf_ff           <= INIT_RF_MODE_RESET;
         led_ff          <= 3'b000;
         sec_load_ff     <= 1'b0;
      end else begin
         if (step) begin
            state_ff        <= state_in;
            step_count_ff   <= step_count_in;
            seconds_left_ff <= seconds_left_in;
            unit_ff         <= unit_in;
            tens_ff         <= tens_in;
            minute_ff       <= minute_in;
            await_ff        <= await_in;
            pending_mode_ff <= pending_mode_in;
            led_ff          <= led_in;
            sec_load_ff     <= sec_load_in;
         end else if (sec_load_ff) begin
            // settle the seconds before a lock time write can change them
            seconds_left_ff <= div_secs;
            sec_load_ff     <= 1'b0;
         end
         if (load.lock_load) lock_ff <= load.lock_value;
         else if (step) lock_ff <= lock_in;
         if (load.rf_load) rf_ff <= load.rf_value;
         else if (step) rf_ff <= rf_in;
      end
   end

   a_sec_load_in_show: assert property (@(posedge clock) disable iff (reset)
      sec_load_ff |-> (state_ff == S_SHOW_CUR_TIME || state_ff == S_SHOW_TIME))
      else $error("seconds load pending outside a time display");

   a_digits_limited: assert property (@(posedge clock) disable iff (reset)
      unit_ff <= DIGIT_MAX && tens_ff <= DIGIT_MAX && minute_ff <= DIGIT_MAX)
      else $error("entry digit beyond its limit");

   a_sec_load_settles: assert property (@(posedge clock) disable iff (reset)
      (sec_load_ff && !step) |=> !sec_load_ff)
      else $error("seconds load not settled");

   a_save_with_show: assert property (@(posedge clock) disable iff (reset)
      (step && result.save_request) |=> (state_ff == S_SHOW_TIME || state_ff == S_SHOW_FREQ))
      else $error("save request without a following display");

endmodule

// ===== src/three_button_setup_menu_top.sv =====
// top level of the three-button set-up menu: stream ports, csr port, result buffer
//
// One request (three button samples of a tick) is taken per clock while the skid register
// is empty; its result, the LED levels, menu flags, pulses and stored settings, comes from
// the combinational menu update between the state registers and is registered in the
// output register, or in the skid register while a result waits there. That skid
// register behind the output register lets one more request in while a result waits.
// The lock time shown as pulses is divided into seconds by a constant reciprocal
// multiply on the registered lock time. Registers lie at byte address 4*index;
// writing the initial lock time or radio mode also loads it into the live setting.
module three_button_setup_menu_top #(
   parameter int TICKS_PER_SECOND = 2,
   parameter int DIGIT_LIMIT      = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] btn_green, [1] btn_yellow, [2] btn_red, [7:3] zero
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] led_levels, [3] menu_active, [4] save_request, [5] stop_request,
   // [6] blink_request, [22:7] lock_ticks_now, [25:23] rf_mode_now, [31:26] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tbsm_pkg::*;

   logic [7:0]  enter_low_ff, enter_high_ff, max_delay_ff;
   logic [15:0] min_lock_ff, max_lock_ff, init_lock_ff;
   logic [2:0]  init_rf_ff;

   cfg_type    cfg;
   load_type   load;
   result_type result;

   logic       out_valid_ff, skid_valid_ff;
   logic [31:0] out_data_ff, skid_data_ff;
   logic [31:0] new_data;
   logic        accept, pop, csr_write;
   logic [2:0]  reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enter_low_ff  <= ENTER_LOW_RESET;
         enter_high_ff <= ENTER_HIGH_RESET;
         max_delay_ff  <= MAX_DELAY_RESET;
         min_lock_ff   <= MIN_LOCK_RESET;
         max_lock_ff   <= MAX_LOCK_RESET;
         init_lock_ff  <= INIT_LOCK_RESET;
         init_rf_ff    <= INIT_RF_MODE_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_ENTER_LOW:    enter_low_ff  <= csr_pwdata[7:0];
            REG_ENTER_HIGH:   enter_high_ff <= csr_pwdata[7:0];
            REG_MAX_DELAY:    max_delay_ff  <= csr_pwdata[7:0];
            REG_MIN_LOCK:     min_lock_ff   <= csr_pwdata[15:0];
            REG_MAX_LOCK:     max_lock_ff   <= csr_pwdata[15:0];
            REG_INIT_LOCK:    init_lock_ff  <= csr_pwdata[15:0];
            REG_INIT_RF_MODE: init_rf_ff    <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ENTER_LOW:    csr_prdata = {24'd0, enter_low_ff};
         REG_ENTER_HIGH:   csr_prdata = {24'd0, enter_high_ff};
         REG_MAX_DELAY:    csr_prdata = {24'd0, max_delay_ff};
         REG_MIN_LOCK:     csr_prdata = {16'd0, min_lock_ff};
         REG_MAX_LOCK:     csr_prdata = {16'd0, max_lock_ff};
         REG_INIT_LOCK:    csr_prdata = {16'd0, init_lock_ff};
         REG_INIT_RF_MODE: csr_prdata = {29'd0, init_rf_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.enter_low      = enter_low_ff;
   assign cfg.enter_high     = enter_high_ff;
   assign cfg.max_delay      = max_delay_ff;
   assign cfg.min_lock_ticks = min_lock_ff;
   assign cfg.max_lock_ticks = max_lock_ff;

   assign load.lock_load  = csr_write && (reg_index == REG_INIT_LOCK);
   assign load.lock_value = csr_pwdata[15:0];
   assign load.rf_load    = csr_write && (reg_index == REG_INIT_RF_MODE);
   assign load.rf_value   = csr_pwdata[2:0];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   tbsm_core #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND),
      .DIGIT_LIMIT     (DIGIT_LIMIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .btn_green (req_tdata[0]),
      .btn_yellow(req_tdata[1]),
      .btn_red   (req_tdata[2]),
      .cfg       (cfg),
      .load      (load),
      .result    (result)
   );

   assign new_data = {6'd0, result.rf_mode_now, result.lock_ticks_now,
                      result.blink_request, result.stop_request, result.save_request,
                      result.menu_active, result.led_levels};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) out_data_ff <= skid_data_ff;
         else if (accept) out_data_ff <= new_data;
      end else if (accept) begin
         skid_data_ff <= new_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output register is empty");

endmodule
